// ----- sv/calchk_pkg.sv -----
// Package: widths, range limits, month tables and mod-7 folding for the date checker.
`default_nettype none
package calchk_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 12;
  localparam int unsigned DoyW   = 9;
  localparam int unsigned WdayW  = 3;
  localparam int unsigned SumW   = 13;
  localparam int unsigned ProdW  = 25;
  localparam int unsigned QuotW  = 6;
  localparam int unsigned LeapW  = 10;

  localparam logic [YearW-1:0]  YearMin      = 12'd1582;
  localparam logic [YearW-1:0]  YearMax      = 12'd2400;
  localparam logic [ProdW-1:0]  Recip100     = 25'd5243;
  localparam int unsigned       Recip100Sh   = 19;
  localparam logic [YearW-1:0]  Hundred      = 12'd100;
  localparam logic [SumW-1:0]   LeapsBefore  = 13'd383;
  localparam logic [SumW-1:0]   WdayOffset   = 13'd3;
  localparam logic [MonthW-1:0] MonthJan     = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb     = 4'd2;
  localparam logic [MonthW-1:0] MonthDec     = 4'd12;

  typedef struct packed {
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } date_t;

  typedef struct packed {
    logic             valid_res;
    logic [DoyW-1:0]  day_of_year;
    logic [WdayW-1:0] weekday;
  } res_t;

  function automatic logic [DoyW-1:0] days_before(input logic [MonthW-1:0] m);
    logic [DoyW-1:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
    logic [DayW-1:0] l;
    case (m)
      4'd2:                 l = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: l = 5'd30;
      default:              l = 5'd31;
    endcase
    return l;
  endfunction

  // Fold octal digits: 8 is 1 mod 7.
  function automatic logic [WdayW-1:0] mod7(input logic [SumW-1:0] s);
    logic [4:0] f1;
    logic [3:0] f2;
    logic [3:0] f3;
    logic [2:0] f4;
    f1 = 5'(s[2:0]) + 5'(s[5:3]) + 5'(s[8:6]) + 5'(s[11:9]) + 5'(s[12]);
    f2 = 4'(f1[2:0]) + 4'(f1[4:3]);
    f3 = 4'(f2[2:0]) + 4'(f2[3]);
    f4 = f3[2:0] + 3'(f3[3]);
    return (f4 == 3'd7) ? 3'd0 : f4;
  endfunction

endpackage
`default_nettype wire

// ----- sv/calchk_if.sv -----
// Interfaces: date input channel and result output channel.
`default_nettype none
interface calchk_in_if;
  import calchk_pkg::*;
  logic              valid;
  logic              ready;
  logic [DayW-1:0]   day;
  logic [MonthW-1:0] month;
  logic [YearW-1:0]  year;
  modport source (output valid, day, month, year, input ready);
  modport sink (input valid, day, month, year, output ready);
endinterface

interface calchk_out_if;
  import calchk_pkg::*;
  logic             valid;
  logic             ready;
  logic             valid_res;
  logic [DoyW-1:0]  day_of_year;
  logic [WdayW-1:0] weekday;
  modport source (output valid, valid_res, day_of_year, weekday, input ready);
  modport sink (input valid, valid_res, day_of_year, weekday, output ready);
endinterface
`default_nettype wire

// ----- sv/calchk_eval.sv -----
// Date evaluation: range checks, leap rule, day of year and weekday.
`default_nettype none
module calchk_eval (
  input  calchk_pkg::date_t date_i,
  output calchk_pkg::res_t  res_o
);
  import calchk_pkg::*;

  logic [ProdW-1:0]  prod_y;
  logic [ProdW-1:0]  prod_n;
  logic [QuotW-1:0]  cent_y;
  logic [QuotW-1:0]  cent_n;
  logic [YearW-1:0]  prev_year;
  logic [LeapW-1:0]  leaps;
  logic              year_ok;
  logic              month_ok;
  logic              day_ok;
  logic              cent_zero;
  logic              leap;
  logic [DayW-1:0]   mlen;
  logic [DoyW-1:0]   doy;
  logic [SumW-1:0]   total;

  always_comb begin
    year_ok  = date_i.year inside {[YearMin:YearMax]};
    month_ok = date_i.month inside {[MonthJan:MonthDec]};

    prod_y    = ProdW'(date_i.year) * Recip100;
    cent_y    = prod_y[ProdW-1:Recip100Sh];
    cent_zero = (date_i.year == YearW'(cent_y) * Hundred);
    leap      = (date_i.year[1:0] == 2'd0 && !cent_zero) ||
                (cent_zero && cent_y[1:0] == 2'd0);

    mlen   = month_len(date_i.month) + DayW'(date_i.month == MonthFeb && leap);
    day_ok = (date_i.day != '0) && (date_i.day <= mlen);

    doy = days_before(date_i.month) + DoyW'(date_i.day)
        + DoyW'(date_i.month > MonthFeb && leap);

    prev_year = date_i.year - YearW'(1);
    prod_n    = ProdW'(prev_year) * Recip100;
    cent_n    = prod_n[ProdW-1:Recip100Sh];
    leaps     = LeapW'(prev_year[YearW-1:2]) - LeapW'(cent_n) + LeapW'(cent_n[QuotW-1:2]);

    // 365 is 1 mod 7, so each year adds one weekday step.
    total = SumW'(date_i.year) - SumW'(YearMin) + SumW'(leaps) - LeapsBefore
          + SumW'(doy) + WdayOffset;

    res_o.valid_res   = year_ok && month_ok && day_ok;
    res_o.day_of_year = res_o.valid_res ? doy : '0;
    res_o.weekday     = res_o.valid_res ? mod7(total) : '0;
  end

endmodule
`default_nettype wire

// ----- sv/calendar_date_check_and_weekday.sv -----
// Top level: input register, date evaluation, result register.
// Path: an accepted date is held in the input register, then its result in the result register on res_o.
// Throughput: one date per cycle unless res_o stalls; the evaluation is one pass of logic
// between the input register and the result register.
// Reset: rst_ni (async, active low) clears both stage valid flags; payload
// registers are not reset.
`default_nettype none
module calendar_date_check_and_weekday (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  calchk_in_if.sink         date_i,
  calchk_out_if.source      res_o
);
  import calchk_pkg::*;

  date_t in_q;
  logic  in_vld_q;
  res_t  res_d;
  res_t  res_q;
  logic  out_vld_q;
  logic  out_free;
  logic  in_free;
  logic  in_acc;

  assign out_free     = !out_vld_q || res_o.ready;
  assign in_free      = !in_vld_q || out_free;
  assign date_i.ready = in_free;
  assign in_acc       = date_i.valid && in_free;

  calchk_eval u_eval (
    .date_i (in_q),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_free) in_vld_q <= date_i.valid;
      if (out_free) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q.day   <= date_i.day;
      in_q.month <= date_i.month;
      in_q.year  <= date_i.year;
    end
    if (out_free && in_vld_q) res_q <= res_d;
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.valid_res   = res_q.valid_res;
  assign res_o.day_of_year = res_q.day_of_year;
  assign res_o.weekday     = res_q.weekday;

  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_vld_q)
    else $error("accepted date not held in input stage");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !out_free |=> in_vld_q && $stable(in_q))
    else $error("input stage changed while stalled");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.valid_res |-> res_o.day_of_year == '0 && res_o.weekday == '0)
    else $error("invalid date with nonzero fields");

  a_valid_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.valid_res |-> res_o.day_of_year != '0 && res_o.weekday != 3'd7)
    else $error("valid date with out-of-range fields");

endmodule
`default_nettype wire

// ----- verif/date_result_checker.sv -----
`timescale 1ns / 1ps
// Checker for the date checker: predicts each result, compares it, counts mismatches.
module date_result_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [calchk_pkg::DayW-1:0]   day_i,
  input  logic [calchk_pkg::MonthW-1:0] month_i,
  input  logic [calchk_pkg::YearW-1:0]  year_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic                          valid_res_i,
  input  logic [calchk_pkg::DoyW-1:0]   day_of_year_i,
  input  logic [calchk_pkg::WdayW-1:0]  weekday_i,
  output int                            pending_o,
  output int                            mismatches_o,
  output int                            results_o,
  output int                            valid_dates_o
);
  import calchk_pkg::*;

  localparam int unsigned MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int unsigned DaysAhead [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                              304, 334};
  localparam int MaxPrinted = 40;

  res_t  expected_res_q [$];
  res_t  want;
  date_t seen_date;
  int    mismatch_cnt = 0;
  int    result_cnt = 0;
  int    valid_cnt = 0;

  assign mismatches_o  = mismatch_cnt;
  assign results_o     = result_cnt;
  assign valid_dates_o = valid_cnt;

  function automatic res_t date_result(input date_t d);
    res_t        r;
    int unsigned y;
    int unsigned m;
    int unsigned dd;
    int unsigned mlen;
    int unsigned doy;
    int unsigned days;
    bit          leap;
    r  = '0;
    y  = d.year;
    m  = d.month;
    dd = d.day;
    if (y < YearMin || y > YearMax) return r;
    if (m < MonthJan || m > MonthDec) return r;
    leap = ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    mlen = MonthDays[m-1];
    if (m == MonthFeb && leap) mlen++;
    if (dd < 1 || dd > mlen) return r;
    doy = DaysAhead[m-1] + dd;
    if (m > MonthFeb && leap) doy++;
    days = (y - YearMin) * 365 + ((y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400)
         - LeapsBefore + doy;
    r.valid_res   = 1'b1;
    r.day_of_year = DoyW'(doy);
    r.weekday     = WdayW'((days + WdayOffset) % 7);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want_val);
    mismatch_cnt++;
    if (mismatch_cnt <= MaxPrinted) begin
      $display("MISMATCH at %0t ns, result %0d: %s got %0d want %0d",
               $realtime, result_cnt, what, got, want_val);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        seen_date.day   = day_i;
        seen_date.month = month_i;
        seen_date.year  = year_i;
        expected_res_q.push_back(date_result(seen_date));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_res_q.size() == 0) begin
          report_mismatch("result with no date waiting, day_of_year", int'(day_of_year_i), 0);
        end else begin
          want = expected_res_q.pop_front();
          if (valid_res_i !== want.valid_res)
            report_mismatch("valid_res", int'(valid_res_i), int'(want.valid_res));
          if (day_of_year_i !== want.day_of_year)
            report_mismatch("day_of_year", int'(day_of_year_i), int'(want.day_of_year));
          if (weekday_i !== want.weekday)
            report_mismatch("weekday", int'(weekday_i), int'(want.weekday));
          if (want.valid_res) valid_cnt++;
        end
        result_cnt++;
      end
      pending_o <= expected_res_q.size();
    end
  end

endmodule

// ----- verif/calendar_date_check_and_weekday_tb.sv -----
`timescale 1ns / 1ps
// Testbench top: clock, reset, date stimulus, output stalls, watchdog and verdict.
module calendar_date_check_and_weekday_tb;
  import calchk_pkg::*;

  localparam int LongHold      = 120;
  localparam int WatchdogLimit = 1000;
  localparam int EndPause      = 6;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  calchk_in_if  date_if ();
  calchk_out_if res_if ();

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit hold_req = 1'b0;
  int stall_left = 0;
  int dates_sent = 0;
  int directed_cnt = 0;
  int quiet_cycles = 0;
  int pending;
  int mismatches;
  int results;
  int valid_dates;

  calendar_date_check_and_weekday uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .date_i (date_if),
    .res_o  (res_if)
  );

  date_result_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (date_if.valid),
    .in_ready_i    (date_if.ready),
    .day_i         (date_if.day),
    .month_i       (date_if.month),
    .year_i        (date_if.year),
    .out_valid_i   (res_if.valid),
    .out_ready_i   (res_if.ready),
    .valid_res_i   (res_if.valid_res),
    .day_of_year_i (res_if.day_of_year),
    .weekday_i     (res_if.weekday),
    .pending_o     (pending),
    .mismatches_o  (mismatches),
    .results_o     (results),
    .valid_dates_o (valid_dates)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
    bit leap;
    leap = ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    case (m)
      2:            return leap ? 29 : 28;
      4, 6, 9, 11:  return 30;
      default:      return 31;
    endcase
  endfunction

  task automatic send_date(input logic [DayW-1:0] d, input logic [MonthW-1:0] m,
                           input logic [YearW-1:0] y);
    int gap;
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      date_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    date_if.valid <= 1'b1;
    date_if.day   <= d;
    date_if.month <= m;
    date_if.year  <= y;
    do @(posedge clk_i); while (!date_if.ready);
    dates_sent++;
  endtask

  task automatic send_random_date();
    int unsigned pick;
    int unsigned y;
    int unsigned m;
    int unsigned d;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      y = $urandom_range(YearMin, YearMax);
      m = $urandom_range(1, 12);
      d = $urandom_range(1, days_in_month(y, m));
    end else if (pick < 85) begin
      case ($urandom_range(0, 4))
        0:       y = YearMin - 1;
        1:       y = YearMin;
        2:       y = YearMax;
        3:       y = YearMax + 1;
        default: y = 4 * $urandom_range(YearMin / 4, YearMax / 4);
      endcase
      m = $urandom_range(0, 13);
      d = $urandom_range(27, 31);
    end else begin
      y = $urandom_range(0, 4095);
      m = $urandom_range(0, 15);
      d = $urandom_range(0, 31);
    end
    send_date(DayW'(d), MonthW'(m), YearW'(y));
  endtask

  initial begin
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = LongHold - 1;
        res_if.ready <= 1'b0;
      end else if (rx_idle && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 12);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((date_if.valid && date_if.ready) || (res_if.valid && res_if.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Watchdog: no item moved for %0d cycles, %0d results outstanding",
                 quiet_cycles, pending);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    date_if.valid = 1'b0;
    date_if.day   = '0;
    date_if.month = '0;
    date_if.year  = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_date(5'd1, 4'd1, 12'd1582);
    send_date(5'd31, 4'd12, 12'd1582);
    send_date(5'd31, 4'd12, 12'd2400);
    send_date(5'd1, 4'd3, 12'd2400);
    send_date(5'd31, 4'd12, 12'd1581);
    send_date(5'd1, 4'd1, 12'd2401);
    send_date(5'd0, 4'd0, 12'd0);
    send_date(5'd31, 4'd15, 12'd4095);
    send_date(5'd15, 4'd0, 12'd2000);
    send_date(5'd15, 4'd13, 12'd2000);
    send_date(5'd15, 4'd15, 12'd2000);
    send_date(5'd0, 4'd6, 12'd1999);
    send_date(5'd31, 4'd4, 12'd1999);
    send_date(5'd30, 4'd4, 12'd1999);
    send_date(5'd31, 4'd1, 12'd2024);
    send_date(5'd29, 4'd2, 12'd1600);
    send_date(5'd29, 4'd2, 12'd1700);
    send_date(5'd28, 4'd2, 12'd1900);
    send_date(5'd29, 4'd2, 12'd2000);
    send_date(5'd30, 4'd2, 12'd2000);
    send_date(5'd29, 4'd2, 12'd2004);
    send_date(5'd29, 4'd2, 12'd2001);
    send_date(5'd31, 4'd12, 12'd2047);
    send_date(5'd1, 4'd1, 12'd2048);
    directed_cnt = dates_sent;

    repeat (140) send_random_date();

    tx_idle = 1'b0;
    hold_req = 1'b1;
    repeat (40) send_random_date();
    tx_idle = 1'b1;

    repeat (140) send_random_date();

    tx_idle = 1'b0;
    rx_idle = 1'b0;
    repeat (60) send_random_date();
    date_if.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (EndPause) @(posedge clk_i);

    $display("Sent %0d dates (%0d directed), checked %0d results, %0d of them valid dates.",
             dates_sent, directed_cnt, results, valid_dates);
    $display("Run had random stalls on both sides, one %0d-cycle output hold, %0d mismatches.",
             LongHold, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
